FILE: rtl/qrm_pkg.sv
// Shared types, constants and the divider step for the quaternion to matrix block.
`default_nettype none
package qrm_pkg;

  localparam int NUM_LANES = 9;
  localparam int Q_BITS    = 15;
  localparam int NORM_W    = 33;
  localparam int NUM_W     = 35;
  localparam int PROD_W    = 32;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // Divider lanes, row-major order of the 3x3 rotation block
  localparam int L00 = 0;
  localparam int L01 = 1;
  localparam int L02 = 2;
  localparam int L10 = 3;
  localparam int L11 = 4;
  localparam int L12 = 5;
  localparam int L20 = 6;
  localparam int L21 = 7;
  localparam int L22 = 8;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [15:0] elem_c0;
    logic signed [15:0] elem_c1;
    logic signed [15:0] elem_c2;
    logic signed [15:0] elem_c3;
    logic               degenerate;
    logic               last_row;
  } out_t;

  typedef struct packed {
    logic              neg;
    logic [NORM_W-1:0] rem;
    logic [Q_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic [NORM_W-1:0]     norm;
  } div_t;

  // One restoring division step; the first step compares the magnitude unshifted
  function automatic lane_t div_step(input lane_t l, input logic [NORM_W-1:0] norm,
                                     input logic first);
    logic [NORM_W:0] t;
    logic            ge;
    lane_t           o;
    t  = first ? {1'b0, l.rem} : {l.rem, 1'b0};
    ge = (t >= {1'b0, norm});
    o.neg = l.neg;
    o.rem = ge ? NORM_W'(t - {1'b0, norm}) : t[NORM_W-1:0];
    o.quo = {l.quo[Q_BITS-2:0], ge};
    return o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/qrm_numer.sv
// Two pipeline stages: component products, then norm and numerator magnitudes.
`default_nettype none
module qrm_numer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  qrm_pkg::in_t     in_data,
  output logic             out_valid,
  output qrm_pkg::div_t    out_data
);
  import qrm_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] sw, sx, sy, sz, xy, zw, xz, yw, yz, xw;
  } prod_t;

  prod_t prod_r;
  logic  va_r;
  div_t  div_r;
  logic  vb_r;

  logic signed [NUM_W-1:0] num [NUM_LANES];
  div_t div_nxt;

  function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
    return NUM_W'(v);
  endfunction

  // Form the nine signed numerators and the squared norm
  always_comb begin
    num[L00] = ext(prod_r.sw) + ext(prod_r.sx) - ext(prod_r.sy) - ext(prod_r.sz);
    num[L11] = ext(prod_r.sw) - ext(prod_r.sx) + ext(prod_r.sy) - ext(prod_r.sz);
    num[L22] = ext(prod_r.sw) - ext(prod_r.sx) - ext(prod_r.sy) + ext(prod_r.sz);
    num[L10] = (ext(prod_r.xy) + ext(prod_r.zw)) <<< 1;
    num[L01] = (ext(prod_r.xy) - ext(prod_r.zw)) <<< 1;
    num[L20] = (ext(prod_r.xz) - ext(prod_r.yw)) <<< 1;
    num[L02] = (ext(prod_r.xz) + ext(prod_r.yw)) <<< 1;
    num[L21] = (ext(prod_r.yz) + ext(prod_r.xw)) <<< 1;
    num[L12] = (ext(prod_r.yz) - ext(prod_r.xw)) <<< 1;
    div_nxt.norm = NORM_W'(prod_r.sw) + NORM_W'(prod_r.sx)
                 + NORM_W'(prod_r.sy) + NORM_W'(prod_r.sz);
    for (int i = 0; i < NUM_LANES; i++) begin
      div_nxt.lane[i].neg = num[i][NUM_W-1];
      div_nxt.lane[i].rem = num[i][NUM_W-1] ? NORM_W'(-num[i]) : NORM_W'(num[i]);
      div_nxt.lane[i].quo = '0;
    end
  end

  // Advance both stages together with the rest of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
    if (en) begin
      prod_r.sw <= PROD_W'(in_data.quat_w) * PROD_W'(in_data.quat_w);
      prod_r.sx <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_x);
      prod_r.sy <= PROD_W'(in_data.quat_y) * PROD_W'(in_data.quat_y);
      prod_r.sz <= PROD_W'(in_data.quat_z) * PROD_W'(in_data.quat_z);
      prod_r.xy <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_y);
      prod_r.zw <= PROD_W'(in_data.quat_z) * PROD_W'(in_data.quat_w);
      prod_r.xz <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_z);
      prod_r.yw <= PROD_W'(in_data.quat_y) * PROD_W'(in_data.quat_w);
      prod_r.yz <= PROD_W'(in_data.quat_y) * PROD_W'(in_data.quat_z);
      prod_r.xw <= PROD_W'(in_data.quat_x) * PROD_W'(in_data.quat_w);
      div_r     <= div_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = div_r;

endmodule
`default_nettype wire

FILE: rtl/qrm_row_ser.sv
// Matrix holding register that hands out the four rows one beat at a time.
`default_nettype none
module qrm_row_ser (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  qrm_pkg::div_t in_data,
  output logic          take,
  output logic          out_valid,
  input  wire logic     out_ready,
  output qrm_pkg::out_t out_data
);
  import qrm_pkg::*;

  logic               busy_r;
  logic [1:0]         row_r;
  logic               degen_r;
  logic signed [15:0] m_r [NUM_LANES];

  logic               degen;
  logic signed [15:0] m_nxt [NUM_LANES];
  logic               load;

  // Apply sign, clamp to one, substitute identity for a zero norm
  always_comb begin
    logic [Q_BITS-1:0] q;
    degen = (in_data.norm == '0);
    for (int i = 0; i < NUM_LANES; i++) begin
      q = in_data.lane[i].quo;
      if (q > Q_BITS'(ONE_Q14)) q = Q_BITS'(ONE_Q14);
      if (degen) begin
        m_nxt[i] = (i == L00 || i == L11 || i == L22) ? ONE_Q14 : 16'sd0;
      end else begin
        m_nxt[i] = in_data.lane[i].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
    end
  end

  assign take = !busy_r || (out_ready && row_r == ROW_LAST);
  assign load = take && in_valid;

  // Hold the matrix, step through rows as beats leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      row_r  <= '0;
    end else if (busy_r && out_ready) begin
      row_r <= row_r + 2'd1;
      if (row_r == ROW_LAST) busy_r <= 1'b0;
    end
    if (load) begin
      degen_r <= degen;
      for (int i = 0; i < NUM_LANES; i++) m_r[i] <= m_nxt[i];
    end
  end

  // Select the current row
  always_comb begin
    out_data.row_index  = row_r;
    out_data.degenerate = degen_r;
    out_data.last_row   = (row_r == ROW_LAST);
    out_data.elem_c3    = 16'sd0;
    case (row_r)
      2'd0: begin
        out_data.elem_c0 = m_r[L00];
        out_data.elem_c1 = m_r[L01];
        out_data.elem_c2 = m_r[L02];
      end
      2'd1: begin
        out_data.elem_c0 = m_r[L10];
        out_data.elem_c1 = m_r[L11];
        out_data.elem_c2 = m_r[L12];
      end
      2'd2: begin
        out_data.elem_c0 = m_r[L20];
        out_data.elem_c1 = m_r[L21];
        out_data.elem_c2 = m_r[L22];
      end
      default: begin
        out_data.elem_c0 = 16'sd0;
        out_data.elem_c1 = 16'sd0;
        out_data.elem_c2 = 16'sd0;
        out_data.elem_c3 = ONE_Q14;
      end
    endcase
  end

  assign out_valid = busy_r;

endmodule
`default_nettype wire

FILE: rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion to homogeneous 4x4 rotation matrix, pipelined.
//
// Input channel in_valid/in_ready/in_data carries one quaternion (w,x,y,z),
// signed Q2.14, per beat. The output channel out_valid/out_ready/out_data
// returns four beats per quaternion, rows 0 to 3 in order, elements in
// signed Q2.14 truncated toward zero; last_row marks row 3. A zero
// quaternion gives the identity with degenerate set on all four rows.
// From input beat to first row beat a quaternion passes two stages of
// products and numerators, fifteen restoring-division stages (one quotient
// bit each, nine lanes sharing the norm), and the row register.
// Throughput is bounded by the four row beats per quaternion on the
// output channel; the pipeline takes a new beat every cycle until the last
// division stage holds a quaternion the row register cannot take.
// When the receiver stalls, beats and gaps keep moving in until that last
// stage is full; then the whole pipeline, gaps included, holds with in_ready low;
// nothing is dropped or repeated. Reset (rst_n low, synchronous) empties
// every stage and the row register.
`default_nettype none
module quaternion_to_rotation_matrix (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  qrm_pkg::in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output qrm_pkg::out_t out_data
);
  import qrm_pkg::*;

  logic  adv;
  logic  take;
  logic  nv;
  div_t  nd;
  logic  dv_r [Q_BITS];
  div_t  dd_r [Q_BITS];

  // Numerators and norm
  qrm_numer u_numer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (nv),
    .out_data  (nd)
  );

  // Advance when the last stage is empty or the row register takes it
  assign adv      = !dv_r[Q_BITS-1] || take;
  assign in_ready = adv;

  // Division stages, one quotient bit each
  for (genvar g = 0; g < Q_BITS; g++) begin : g_div
    logic  v_in;
    div_t  d_in;
    div_t  d_nxt;
    if (g == 0) begin : g_first
      assign v_in = nv;
      assign d_in = nd;
    end else begin : g_next
      assign v_in = dv_r[g-1];
      assign d_in = dd_r[g-1];
    end
    always_comb begin
      d_nxt.norm = d_in.norm;
      for (int i = 0; i < NUM_LANES; i++)
        d_nxt.lane[i] = div_step(d_in.lane[i], d_in.norm, (g == 0));
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g] <= 1'b0;
      end else if (adv) begin
        dv_r[g] <= v_in;
      end
      if (adv) dd_r[g] <= d_nxt;
    end
  end

  // Row serializer
  qrm_row_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_r[Q_BITS-1]),
    .in_data   (dd_r[Q_BITS-1]),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Degenerate beats carry the identity in row 0
  a_degen_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate && out_data.row_index == 2'd0
    |-> out_data.elem_c0 == ONE_Q14 && out_data.elem_c1 == 16'sd0)
    else $error("degenerate row 0 not identity");

  // Rotation elements stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.elem_c0 <= ONE_Q14 && out_data.elem_c0 >= -ONE_Q14
                  && out_data.elem_c1 <= ONE_Q14 && out_data.elem_c1 >= -ONE_Q14
                  && out_data.elem_c2 <= ONE_Q14 && out_data.elem_c2 >= -ONE_Q14)
    else $error("element out of range");

  // A delivered non-final row is followed by the next row of the same matrix
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_row
    |=> out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for the quaternion to rotation matrix block: directed and random quaternions.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import qrm_pkg::*;

  localparam int IDLE_MAX   = 17;
  localparam int RANDOM_CNT = 233;
  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 200;

  // Track expected matrix rows and compare every output beat against the oldest one
  class matrix_board;
    out_t row_q[$];
    int   mismatches;

    // (num * 2^14) / norm, truncated toward zero, clamped to +-1.0
    function automatic logic signed [15:0] ratio_q14(longint num, longint norm);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag * 16384) / norm;
      if (q > 16384) q = 16384;
      return (num < 0) ? 16'(-q) : 16'(q);
    endfunction

    // Predict all four rows of one quaternion
    function void note_quat(in_t qt);
      longint w, x, y, z, sw, sx, sy, sz, norm;
      logic signed [15:0] m [4][4];
      out_t o;
      w = qt.quat_w; x = qt.quat_x; y = qt.quat_y; z = qt.quat_z;
      sw = w * w; sx = x * x; sy = y * y; sz = z * z;
      norm = sw + sx + sy + sz;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          m[r][c] = (r == c) ? ONE_Q14 : 16'sd0;
      if (norm != 0) begin
        m[0][0] = ratio_q14(sx - sy - sz + sw, norm);
        m[1][1] = ratio_q14(-sx + sy - sz + sw, norm);
        m[2][2] = ratio_q14(-sx - sy + sz + sw, norm);
        m[1][0] = ratio_q14(2 * (x * y + z * w), norm);
        m[0][1] = ratio_q14(2 * (x * y - z * w), norm);
        m[2][0] = ratio_q14(2 * (x * z - y * w), norm);
        m[0][2] = ratio_q14(2 * (x * z + y * w), norm);
        m[2][1] = ratio_q14(2 * (y * z + x * w), norm);
        m[1][2] = ratio_q14(2 * (y * z - x * w), norm);
      end
      for (int r = 0; r < 4; r++) begin
        o.row_index  = 2'(r);
        o.elem_c0    = m[r][0];
        o.elem_c1    = m[r][1];
        o.elem_c2    = m[r][2];
        o.elem_c3    = m[r][3];
        o.degenerate = (norm == 0);
        o.last_row   = (2'(r) == ROW_LAST);
        row_q.push_back(o);
      end
    endfunction

    function void check_row(out_t got);
      out_t exp_row;
      if (row_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row beat %p", got);
        return;
      end
      exp_row = row_q.pop_front();
      if (got !== exp_row) begin
        mismatches++;
        if (mismatches <= 10) $display("row mismatch: expected %p got %p", exp_row, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  matrix_board board = new();
  bit   hold_rx = 1'b0;
  bit   rx_gaps = 1'b1;
  bit   tx_gaps = 1'b1;
  int   idle_cnt = 0;

  quaternion_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted quaternions and check output beats at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_quat(in_data);
    if (rst_n && out_valid && out_ready) board.check_row(out_data);
  end

  // Watchdog: count cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("quaternion_to_rotation_matrix verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls per beat, or a long hold when asked
  initial begin : rx_proc
    int wait_n;
    @(posedge clk iff rst_n);
    forever begin
      wait_n = rx_gaps ? int'($urandom_range(0, IDLE_MAX)) : 0;
      if (hold_rx) begin
        wait_n = wait_n + LONG_HOLD;
        hold_rx = 1'b0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Offer one quaternion and hold it until accepted
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int wait_n;
    wait_n = tx_gaps ? int'($urandom_range(0, IDLE_MAX)) : 0;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
    @(posedge clk iff in_ready);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.row_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero quaternion, identity, axes, extremes, sign mixes
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'hffff, 16'hffff, 16'h0001, 16'h0001);
    send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001);
    send_quat(16'h2d41, 16'h2d41, 16'h0000, 16'h0000);
    send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0001);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);

    // Pause until every expected row has come
    drain();

    // Long receiver hold while items keep coming, back to back
    tx_gaps = 1'b0;
    hold_rx = 1'b1;
    for (int i = 0; i < 30; i++) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    drain();

    // Random stream with gap and no-gap stretches
    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (i % 70 == 0) begin
        tx_gaps = 1'($urandom_range(0, 1));
        rx_gaps = 1'($urandom_range(0, 1));
      end
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    drain();
    repeat (30) @(posedge clk);

    if (board.mismatches == 0 && board.row_q.size() == 0) begin
      $display("quaternion_to_rotation_matrix verification clean");
    end else begin
      $display("quaternion_to_rotation_matrix verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/qrm_pkg.sv
rtl/qrm_numer.sv
rtl/qrm_row_ser.sv
rtl/quaternion_to_rotation_matrix.sv
tb/sv/testbench.sv
